// ===== hdl/mabs_pkg.sv =====
// Shared types and constants for the multi-alarm bell scheduler.
package mabs_pkg;

  localparam int NUM_ENTRIES_DEF = 8;

  localparam int CMD_W    = 3;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int DUR_W    = 6;
  localparam int CNT_W    = 8;
  localparam int FIELD_W  = 2;
  localparam int SELOUT_W = 3;
  localparam int ENTRY_W  = HOUR_W + MINUTE_W + DUR_W;

  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DOWN = 3'd4;

  localparam logic [FIELD_W-1:0] FIELD_HOUR     = 2'd0;
  localparam logic [FIELD_W-1:0] FIELD_MINUTE   = 2'd1;
  localparam logic [FIELD_W-1:0] FIELD_DURATION = 2'd2;

  localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
  localparam logic [DUR_W-1:0]    DUR_RESET   = 6'd3;
  localparam logic [DUR_W-1:0]    MAX_DUR_RESET = 6'd30;
  localparam logic [CNT_W-1:0]    CNT_MAX     = 8'd255;

  // What an accepted word asks of the controller.
  typedef enum logic [1:0] {
    KIND_SHOW,
    KIND_WALK,
    KIND_EDIT
  } kind_e;

  typedef struct packed {
    logic capture;
    logic walk;
    logic rd_sel;
    logic edit_wr;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  walk_last;
  } dp_status_t;

endpackage

// ===== hdl/mabs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mabs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mabs_dpath.sv =====
// Datapath: alarm table, countdown, edit state and the result register.
module mabs_dpath #(
  parameter int NUM_ENTRIES = mabs_pkg::NUM_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mabs_pkg::ctrl_cmd_t            cmd_i,
  output mabs_pkg::dp_status_t           status_o,
  input  logic                           cfg_we_i,
  input  logic [mabs_pkg::DUR_W-1:0]     cfg_wdata_i,
  input  logic [mabs_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [mabs_pkg::HOUR_W-1:0]    tod_hour_i,
  input  logic [mabs_pkg::MINUTE_W-1:0]  tod_minute_i,
  input  logic [mabs_pkg::SECOND_W-1:0]  tod_second_i,
  output logic                           bell_on_o,
  output logic [mabs_pkg::CNT_W-1:0]     seconds_left_o,
  output logic                           edit_mode_o,
  output logic [mabs_pkg::FIELD_W-1:0]   edit_field_o,
  output logic [mabs_pkg::SELOUT_W-1:0]  selected_entry_o,
  output logic [mabs_pkg::HOUR_W-1:0]    entry_hour_o,
  output logic [mabs_pkg::MINUTE_W-1:0]  entry_minute_o,
  output logic [mabs_pkg::DUR_W-1:0]     entry_duration_o
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ENTRIES - 1);

  // Captured event word.
  logic [mabs_pkg::CMD_W-1:0]    ev_cmd_q;
  logic [mabs_pkg::HOUR_W-1:0]   ev_hour_q;
  logic [mabs_pkg::MINUTE_W-1:0] ev_minute_q;

  // Control state.
  logic [mabs_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         editing_q, editing_d;
  logic [mabs_pkg::FIELD_W-1:0] field_q, field_d;
  logic [IDX_W-1:0]             sel_q, sel_d;
  logic [IDX_W-1:0]             walk_q, walk_d;
  logic [IDX_W-1:0]             rd_addr_q;
  logic                         pend_q;
  logic [NUM_ENTRIES-1:0]       valid_q, valid_d;
  logic [mabs_pkg::DUR_W-1:0]   max_dur_q;

  // Result payload.
  logic                            out_bell_q;
  logic [mabs_pkg::CNT_W-1:0]      out_cnt_q;
  logic                            out_edit_q;
  logic [mabs_pkg::FIELD_W-1:0]    out_field_q;
  logic [mabs_pkg::SELOUT_W-1:0]   out_sel_q;
  logic [mabs_pkg::HOUR_W-1:0]     out_hour_q;
  logic [mabs_pkg::MINUTE_W-1:0]   out_minute_q;
  logic [mabs_pkg::DUR_W-1:0]      out_dur_q;

  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  logic [mabs_pkg::ENTRY_W-1:0]    ram_rdata;
  logic [mabs_pkg::ENTRY_W-1:0]    ent_word;
  logic [mabs_pkg::ENTRY_W-1:0]    new_word;
  logic [mabs_pkg::HOUR_W-1:0]     ent_hour, new_hour;
  logic [mabs_pkg::MINUTE_W-1:0]   ent_minute, new_minute;
  logic [mabs_pkg::DUR_W-1:0]      ent_dur, dur_lim, dur_dn;
  logic [mabs_pkg::DUR_W:0]        dur_new;
  logic [mabs_pkg::CNT_W:0]        cnt_sum;
  logic                            up;
  logic [IDX_W+2:0]                sel_ext;

  assign rd_en   = cmd_i.walk | cmd_i.rd_sel;
  assign rd_addr = cmd_i.walk ? walk_q : sel_q;

  mabs_ram #(
    .WIDTH (mabs_pkg::ENTRY_W),
    .DEPTH (NUM_ENTRIES),
    .AW    (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.edit_wr),
    .waddr_i (rd_addr_q),
    .wdata_i (new_word),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // An entry that was never edited still holds its reset contents.
  assign ent_word = valid_q[rd_addr_q] ? ram_rdata
                  : {mabs_pkg::HOUR_W'(0), mabs_pkg::MINUTE_W'(0), mabs_pkg::DUR_RESET};
  assign {ent_hour, ent_minute, ent_dur} = ent_word;

  // Edit arithmetic on the selected entry.
  assign up      = (ev_cmd_q == mabs_pkg::CMD_UP);
  assign dur_lim = (max_dur_q == '0) ? mabs_pkg::DUR_W'(1) : max_dur_q;
  assign dur_dn  = (ent_dur == '0) ? '0 : ent_dur - mabs_pkg::DUR_W'(1);

  always_comb begin
    new_hour   = ent_hour;
    new_minute = ent_minute;
    dur_new    = {1'b0, ent_dur};
    case (field_q)
      mabs_pkg::FIELD_HOUR: begin
        if (up) begin
          new_hour = (ent_hour >= mabs_pkg::HOUR_LAST) ? '0 : ent_hour + mabs_pkg::HOUR_W'(1);
        end else begin
          new_hour = (ent_hour == '0) ? mabs_pkg::HOUR_LAST : ent_hour - mabs_pkg::HOUR_W'(1);
        end
      end
      mabs_pkg::FIELD_MINUTE: begin
        if (up) begin
          new_minute = (ent_minute >= mabs_pkg::MINUTE_LAST) ? '0
                     : ent_minute + mabs_pkg::MINUTE_W'(1);
        end else begin
          new_minute = (ent_minute == '0) ? mabs_pkg::MINUTE_LAST
                     : ent_minute - mabs_pkg::MINUTE_W'(1);
        end
      end
      default: begin
        dur_new = up ? {1'b0, ent_dur} + (mabs_pkg::DUR_W + 1)'(1) : {1'b0, dur_dn};
        if (dur_new == '0) begin
          dur_new = (mabs_pkg::DUR_W + 1)'(1);
        end
        if (dur_new > {1'b0, dur_lim}) begin
          dur_new = {1'b0, dur_lim};
        end
      end
    endcase
  end

  assign new_word = {new_hour, new_minute, dur_new[mabs_pkg::DUR_W-1:0]};

  assign cnt_sum = {1'b0, cnt_q} + (mabs_pkg::CNT_W + 1)'(ent_dur);

  always_comb begin
    cnt_d     = cnt_q;
    editing_d = editing_q;
    field_d   = field_q;
    sel_d     = sel_q;
    walk_d    = walk_q;
    valid_d   = valid_q;
    if (cmd_i.capture) begin
      walk_d = '0;
      case (in_cmd_i)
        mabs_pkg::CMD_TICK: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - mabs_pkg::CNT_W'(1);
          end
        end
        mabs_pkg::CMD_SET: begin
          editing_d = ~editing_q;
        end
        mabs_pkg::CMD_NEXT: begin
          if (editing_q) begin
            field_d = (field_q == mabs_pkg::FIELD_DURATION) ? mabs_pkg::FIELD_HOUR
                    : field_q + mabs_pkg::FIELD_W'(1);
          end else begin
            sel_d = (sel_q == IDX_LAST) ? '0 : sel_q + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.walk) begin
      walk_d = walk_q + IDX_W'(1);
    end
    // Read data of the previous walk step arrives here.
    if (pend_q && ent_hour == ev_hour_q && ent_minute == ev_minute_q) begin
      cnt_d = cnt_sum[mabs_pkg::CNT_W] ? mabs_pkg::CNT_MAX : cnt_sum[mabs_pkg::CNT_W-1:0];
    end
    if (cmd_i.edit_wr) begin
      valid_d[rd_addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      editing_q <= 1'b0;
      field_q   <= mabs_pkg::FIELD_HOUR;
      sel_q     <= '0;
      walk_q    <= '0;
      pend_q    <= 1'b0;
      valid_q   <= '0;
      max_dur_q <= mabs_pkg::MAX_DUR_RESET;
    end else begin
      cnt_q     <= cnt_d;
      editing_q <= editing_d;
      field_q   <= field_d;
      sel_q     <= sel_d;
      walk_q    <= walk_d;
      pend_q    <= cmd_i.walk;
      valid_q   <= valid_d;
      if (cfg_we_i) begin
        max_dur_q <= cfg_wdata_i;
      end
    end
  end

  assign sel_ext = {3'b000, sel_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ev_cmd_q    <= in_cmd_i;
      ev_hour_q   <= tod_hour_i;
      ev_minute_q <= tod_minute_i;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (cmd_i.load_out) begin
      out_bell_q   <= (cnt_q != '0);
      out_cnt_q    <= cnt_q;
      out_edit_q   <= editing_q;
      out_field_q  <= field_q;
      out_sel_q    <= sel_ext[mabs_pkg::SELOUT_W-1:0];
      out_hour_q   <= ent_hour;
      out_minute_q <= ent_minute;
      out_dur_q    <= ent_dur;
    end
  end

  always_comb begin
    status_o.walk_last = (walk_q == IDX_LAST);
    if (in_cmd_i == mabs_pkg::CMD_TICK && tod_second_i == '0) begin
      status_o.kind = mabs_pkg::KIND_WALK;
    end else if ((in_cmd_i == mabs_pkg::CMD_UP || in_cmd_i == mabs_pkg::CMD_DOWN)
                 && editing_q) begin
      status_o.kind = mabs_pkg::KIND_EDIT;
    end else begin
      status_o.kind = mabs_pkg::KIND_SHOW;
    end
  end

  assign bell_on_o        = out_bell_q;
  assign seconds_left_o   = out_cnt_q;
  assign edit_mode_o      = out_edit_q;
  assign edit_field_o     = out_field_q;
  assign selected_entry_o = out_sel_q;
  assign entry_hour_o     = out_hour_q;
  assign entry_minute_o   = out_minute_q;
  assign entry_duration_o = out_dur_q;

endmodule

// ===== hdl/mabs_ctrl.sv =====
// Controller: sequences one event word through the datapath and owns the result handshake.
module mabs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  mabs_pkg::dp_status_t status_i,
  output mabs_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EDIT_RD,
    ST_EDIT_WR,
    ST_SHOW_RD,
    ST_SHOW_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.walk     = (state_q == ST_WALK);
    cmd_o.rd_sel   = (state_q == ST_EDIT_RD) || (state_q == ST_SHOW_RD);
    cmd_o.edit_wr  = (state_q == ST_EDIT_WR);
    cmd_o.load_out = (state_q == ST_SHOW_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if (state_q == ST_SHOW_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (status_i.kind)
              mabs_pkg::KIND_WALK: state_q <= ST_WALK;
              mabs_pkg::KIND_EDIT: state_q <= ST_EDIT_RD;
              default:             state_q <= ST_SHOW_RD;
            endcase
          end
        end
        ST_WALK: begin
          if (status_i.walk_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN:   state_q <= ST_SHOW_RD;
        ST_EDIT_RD: state_q <= ST_EDIT_WR;
        ST_EDIT_WR: state_q <= ST_SHOW_RD;
        ST_SHOW_RD: state_q <= ST_SHOW_OUT;
        ST_SHOW_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/multi_alarm_bell_scheduler_unit.sv =====
// Top level of the multi-alarm bell scheduler.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  cmd_i, tod_hour_i, tod_minute_i, tod_second_i
//   out      output     out_valid_o/out_stall_i  bell_on_o ... entry_duration_o
//   cfg      input      cfg_we_i               cfg_wdata_i (max_duration)
//
// A tick at second zero goes through the walk, drain, show-read and show-out states, the walk
// reading one entry per cycle from the alarm RAM. An up or down in edit mode goes through edit-read,
// edit-write, show-read and show-out; every other word goes through show-read and show-out only.
// The next word is accepted while a result still waits in the output register.
// Reset restores the table to 00:00 with 3 seconds through per-entry valid bits,
// so no clearing pass is needed.
module multi_alarm_bell_scheduler_unit #(
  parameter int NUM_ENTRIES = mabs_pkg::NUM_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mabs_pkg::DUR_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mabs_pkg::CMD_W-1:0]     cmd_i,
  input  logic [mabs_pkg::HOUR_W-1:0]    tod_hour_i,
  input  logic [mabs_pkg::MINUTE_W-1:0]  tod_minute_i,
  input  logic [mabs_pkg::SECOND_W-1:0]  tod_second_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           bell_on_o,
  output logic [mabs_pkg::CNT_W-1:0]     seconds_left_o,
  output logic                           edit_mode_o,
  output logic [mabs_pkg::FIELD_W-1:0]   edit_field_o,
  output logic [mabs_pkg::SELOUT_W-1:0]  selected_entry_o,
  output logic [mabs_pkg::HOUR_W-1:0]    entry_hour_o,
  output logic [mabs_pkg::MINUTE_W-1:0]  entry_minute_o,
  output logic [mabs_pkg::DUR_W-1:0]     entry_duration_o
);

  mabs_pkg::ctrl_cmd_t  ctrl_cmd;
  mabs_pkg::dp_status_t dp_status;

  mabs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  mabs_dpath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .status_o         (dp_status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_cmd_i         (cmd_i),
    .tod_hour_i       (tod_hour_i),
    .tod_minute_i     (tod_minute_i),
    .tod_second_i     (tod_second_i),
    .bell_on_o        (bell_on_o),
    .seconds_left_o   (seconds_left_o),
    .edit_mode_o      (edit_mode_o),
    .edit_field_o     (edit_field_o),
    .selected_entry_o (selected_entry_o),
    .entry_hour_o     (entry_hour_o),
    .entry_minute_o   (entry_minute_o),
    .entry_duration_o (entry_duration_o)
  );

endmodule

// ===== hdl/mabs_sva.sv =====
// Port-level checker for the bell scheduler and its bind to the top level.
module mabs_sva (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           bell_on_o,
  input logic [mabs_pkg::CNT_W-1:0]     seconds_left_o,
  input logic [mabs_pkg::FIELD_W-1:0]   edit_field_o,
  input logic [mabs_pkg::DUR_W-1:0]     entry_duration_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(seconds_left_o))
    else $error("stalled result word changed");

  // The bell follows the countdown it reports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bell_on_o == (seconds_left_o != '0)))
    else $error("bell_on disagrees with seconds_left");

  // One word at a time: the block is busy right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again directly after an accept");

  // The edited field is hour, minute or duration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (edit_field_o == mabs_pkg::FIELD_HOUR ||
                     edit_field_o == mabs_pkg::FIELD_MINUTE ||
                     edit_field_o == mabs_pkg::FIELD_DURATION))
    else $error("edit_field out of range");

  // A stored duration is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_duration_o != '0)
    else $error("entry duration is zero");

endmodule

bind multi_alarm_bell_scheduler_unit mabs_sva u_sva (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .bell_on_o        (bell_on_o),
  .seconds_left_o   (seconds_left_o),
  .edit_field_o     (edit_field_o),
  .entry_duration_o (entry_duration_o)
);

// ===== test/tb_multi_alarm_bell_scheduler_unit.sv =====
// Self-checking testbench for the multi-alarm bell scheduler with a cycle-free status predictor.
module tb_multi_alarm_bell_scheduler_unit;
  import mabs_pkg::*;

  localparam int NUM_ENT = NUM_ENTRIES_DEF;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [DUR_W-1:0] DUR_TOP = '1;
  localparam int RAND_TOD_HOUR = (1 << HOUR_W) - 1;
  localparam int RAND_TOD_SUB = (1 << MINUTE_W) - 1;

  typedef struct packed {
    logic                bell;
    logic [CNT_W-1:0]    left;
    logic                edit;
    logic [FIELD_W-1:0]  field;
    logic [SELOUT_W-1:0] sel;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [DUR_W-1:0]    dur;
  } bell_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [DUR_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    cmd_i = CMD_TICK;
  logic [HOUR_W-1:0]   tod_hour_i = '0;
  logic [MINUTE_W-1:0] tod_minute_i = '0;
  logic [SECOND_W-1:0] tod_second_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                bell_on_o;
  logic [CNT_W-1:0]    seconds_left_o;
  logic                edit_mode_o;
  logic [FIELD_W-1:0]  edit_field_o;
  logic [SELOUT_W-1:0] selected_entry_o;
  logic [HOUR_W-1:0]   entry_hour_o;
  logic [MINUTE_W-1:0] entry_minute_o;
  logic [DUR_W-1:0]    entry_duration_o;

  // Predicted scheduler state.
  logic [HOUR_W-1:0]   alarm_hr [NUM_ENT];
  logic [MINUTE_W-1:0] alarm_min [NUM_ENT];
  logic [DUR_W-1:0]    alarm_dur [NUM_ENT];
  int unsigned         ring_left;
  logic                in_edit;
  logic [FIELD_W-1:0]  edit_sel;
  int unsigned         entry_sel;
  logic [DUR_W-1:0]    dur_limit;

  bell_status_t status_due [$];
  int unsigned  fail_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  gap_pct = 20;
  int unsigned  stall_pct = 20;
  int unsigned  stall_left = 0;

  multi_alarm_bell_scheduler_unit #(
    .NUM_ENTRIES(NUM_ENT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .tod_hour_i      (tod_hour_i),
    .tod_minute_i    (tod_minute_i),
    .tod_second_i    (tod_second_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bell_on_o       (bell_on_o),
    .seconds_left_o  (seconds_left_o),
    .edit_mode_o     (edit_mode_o),
    .edit_field_o    (edit_field_o),
    .selected_entry_o(selected_entry_o),
    .entry_hour_o    (entry_hour_o),
    .entry_minute_o  (entry_minute_o),
    .entry_duration_o(entry_duration_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one accepted word to the predicted state and returns the status it reports.
  function automatic bell_status_t advance_schedule(logic [CMD_W-1:0] cmd,
                                                    logic [HOUR_W-1:0] th,
                                                    logic [MINUTE_W-1:0] tm,
                                                    logic [SECOND_W-1:0] ts);
    bell_status_t st;
    int unsigned lim;
    int unsigned d;
    if (cmd == CMD_TICK) begin
      if (ring_left != 0) ring_left--;
      if (ts == 0) begin
        for (int i = 0; i < NUM_ENT; i++) begin
          if (alarm_hr[i] == th && alarm_min[i] == tm) begin
            ring_left += alarm_dur[i];
            if (ring_left > CNT_MAX) ring_left = CNT_MAX;
          end
        end
      end
    end else if (cmd == CMD_SET) begin
      in_edit = !in_edit;
    end else if (cmd == CMD_NEXT) begin
      if (in_edit) begin
        edit_sel = (edit_sel == FIELD_DURATION) ? FIELD_HOUR : edit_sel + 1'b1;
      end else begin
        entry_sel = (entry_sel + 1) % NUM_ENT;
      end
    end else if ((cmd == CMD_UP || cmd == CMD_DOWN) && in_edit) begin
      if (edit_sel == FIELD_HOUR) begin
        if (cmd == CMD_UP) begin
          alarm_hr[entry_sel] = (alarm_hr[entry_sel] == HOUR_LAST) ? '0
                                : alarm_hr[entry_sel] + 1'b1;
        end else begin
          alarm_hr[entry_sel] = (alarm_hr[entry_sel] == 0) ? HOUR_LAST
                                : alarm_hr[entry_sel] - 1'b1;
        end
      end else if (edit_sel == FIELD_MINUTE) begin
        if (cmd == CMD_UP) begin
          alarm_min[entry_sel] = (alarm_min[entry_sel] == MINUTE_LAST) ? '0
                                 : alarm_min[entry_sel] + 1'b1;
        end else begin
          alarm_min[entry_sel] = (alarm_min[entry_sel] == 0) ? MINUTE_LAST
                                 : alarm_min[entry_sel] - 1'b1;
        end
      end else begin
        // A zero limit behaves as a limit of one second.
        lim = (dur_limit == 0) ? 1 : dur_limit;
        d = alarm_dur[entry_sel];
        if (cmd == CMD_UP) d = d + 1;
        else if (d != 0) d = d - 1;
        if (d < 1) d = 1;
        if (d > lim) d = lim;
        alarm_dur[entry_sel] = d[DUR_W-1:0];
      end
    end
    st.bell   = (ring_left != 0);
    st.left   = ring_left[CNT_W-1:0];
    st.edit   = in_edit;
    st.field  = edit_sel;
    st.sel    = entry_sel[SELOUT_W-1:0];
    st.hour   = alarm_hr[entry_sel];
    st.minute = alarm_min[entry_sel];
    st.dur    = alarm_dur[entry_sel];
    return st;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Receiver side: random stall bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    bell_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due.size() == 0) begin
        $display("%0t: status word with none expected, actual seconds_left %0d",
                 $time, seconds_left_o);
        fail_count++;
      end else begin
        want = status_due.pop_front();
        check_field("bell_on", want.bell, bell_on_o);
        check_field("seconds_left", want.left, seconds_left_o);
        check_field("edit_mode", want.edit, edit_mode_o);
        check_field("edit_field", want.field, edit_field_o);
        check_field("selected_entry", want.sel, selected_entry_o);
        check_field("entry_hour", want.hour, entry_hour_o);
        check_field("entry_minute", want.minute, entry_minute_o);
        check_field("entry_duration", want.dur, entry_duration_o);
      end
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [HOUR_W-1:0] th,
                           logic [MINUTE_W-1:0] tm, logic [SECOND_W-1:0] ts);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    tod_hour_i   <= th;
    tod_minute_i <= tm;
    tod_second_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
    status_due.push_back(advance_schedule(cmd, th, tm, ts));
    items_sent++;
  endtask

  // Buttons ignore the time of day, so it is filled with noise.
  task automatic send_button(logic [CMD_W-1:0] cmd);
    send_word(cmd, HOUR_W'($urandom_range(0, RAND_TOD_HOUR)),
              MINUTE_W'($urandom_range(0, RAND_TOD_SUB)),
              SECOND_W'($urandom_range(0, RAND_TOD_SUB)));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_max_duration(logic [DUR_W-1:0] value);
    wait_for_results();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    dur_limit = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // All entries start at midnight, so repeated ticks there pile up until the countdown saturates.
  task automatic test_ring_saturation();
    repeat (12) send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_TICK, '0, '0, '1);
    send_word(CMD_TICK, '1, '1, '0);
  endtask

  task automatic test_edit_wrap();
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) send_button(CMD_W'(c));
    send_button(CMD_UP);
    send_button(CMD_DOWN);
    send_button(CMD_SET);
    send_button(CMD_UP);
    send_button(CMD_DOWN);
    send_button(CMD_DOWN);
    send_button(CMD_UP);
    send_button(CMD_NEXT);
    send_button(CMD_DOWN);
    send_button(CMD_UP);
    send_button(CMD_NEXT);
    repeat (3) send_button(CMD_DOWN);
  endtask

  task automatic test_duration_limit();
    set_max_duration('0);
    send_button(CMD_UP);
    set_max_duration(DUR_TOP);
    send_button(CMD_UP);
    send_button(CMD_NEXT);
    send_button(CMD_SET);
    send_button(CMD_NEXT);
  endtask

  // Mostly edit sessions and ticks at programmed alarm times, with some raw noise.
  task automatic test_random_traffic(int unsigned count, bit quiet);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned idx;
    int unsigned run;
    logic [FIELD_W-1:0] target;
    logic [CMD_W-1:0] step_cmd;
    stop_at = items_sent + count;
    if (quiet) begin
      gap_pct = 0;
      stall_pct = 0;
    end
    while (items_sent < stop_at) begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        gap_pct = 15 * $urandom_range(0, 3);
        stall_pct = 15 * $urandom_range(0, 3);
      end
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        if (!in_edit) begin
          repeat ($urandom_range(0, 3)) send_button(CMD_NEXT);
          send_button(CMD_SET);
        end
        target = FIELD_W'($urandom_range(FIELD_HOUR, FIELD_DURATION));
        while (edit_sel != target) send_button(CMD_NEXT);
        run = (target == FIELD_DURATION) ? $urandom_range(1, 70) : $urandom_range(1, 30);
        step_cmd = $urandom_range(0, 1) ? CMD_UP : CMD_DOWN;
        repeat (run) begin
          if ($urandom_range(0, 7) == 0) send_button(CMD_W'($urandom_range(CMD_UP, CMD_DOWN)));
          else send_button(step_cmd);
        end
        if ($urandom_range(0, 3) != 0) send_button(CMD_SET);
      end else if (kind < 8) begin
        repeat ($urandom_range(1, 12)) begin
          idx = $urandom_range(0, NUM_ENT - 1);
          send_word(CMD_TICK, alarm_hr[idx], alarm_min[idx],
                    ($urandom_range(0, 2) != 0) ? '0
                    : SECOND_W'($urandom_range(0, RAND_TOD_SUB)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_word(CMD_W'($urandom_range(0, CMD_SPARE_HI)),
                    HOUR_W'($urandom_range(0, RAND_TOD_HOUR)),
                    MINUTE_W'($urandom_range(0, RAND_TOD_SUB)),
                    SECOND_W'($urandom_range(0, RAND_TOD_SUB)));
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_ENT; i++) begin
      alarm_hr[i]  = '0;
      alarm_min[i] = '0;
      alarm_dur[i] = DUR_RESET;
    end
    ring_left = 0;
    in_edit   = 1'b0;
    edit_sel  = FIELD_HOUR;
    entry_sel = 0;
    dur_limit = MAX_DUR_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ring_saturation();
    test_edit_wrap();
    test_duration_limit();
    test_random_traffic(200, 1'b0);
    set_max_duration(6'd1);
    test_random_traffic(200, 1'b0);
    set_max_duration(DUR_W'($urandom_range(2, DUR_TOP - 1)));
    test_random_traffic(200, 1'b0);
    set_max_duration(DUR_TOP);
    test_random_traffic(200, 1'b0);
    set_max_duration(MAX_DUR_RESET);
    test_random_traffic(200, 1'b1);

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
